[hdl/plti_pkg.sv]
// ----------------------------------------------------------------------------
// plti_pkg: shared types and constants for the table interpolator
// Table geometry, controller states, and the command and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package plti_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = ADDR_W + 1;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int LEN_W  = 5;
    localparam int PROD_W = 2 * VAL_W;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = VAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Input kind carried on s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INSIDE = 2'd1,
        REGION_BEYOND = 2'd2
    } region_t;

    typedef enum logic [1:0] {
        RES_CUR_Y,
        RES_AVG,
        RES_QUOT
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ0,
        ST_FIRST,
        ST_SCAN,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_PREP,
        ST_DIV,
        ST_DIV_END,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     wr_entry;   // write one breakpoint from the input
        logic     start;      // latch query, restart scan at entry zero
        logic     idx_inc;    // advance scan read address
        logic     prev_load;  // current entry becomes previous entry
        logic     seg_load;   // latch the matched segment
        logic     mul_a;      // left product
        logic     mul_b;      // move left product, form right product
        logic     mul_c;      // sum products
        logic     div_prep;   // take magnitude, seed divider
        logic     div_step;   // one restoring division step
        logic     res_load;   // capture result and region
        res_sel_t res_sel;
        region_t  region;
        logic     out_load;   // move result into output register
    } plti_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic below;      // query below current entry x
        logic hit;        // query inside previous..current segment
        logic last;       // current entry is last one in use
        logic span_zero;  // segment has zero width
        logic div_last;   // final division step
    } plti_status_t;

endpackage

[hdl/plti_ram.sv]
// ----------------------------------------------------------------------------
// plti_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module plti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/plti_ctrl.sv]
// ----------------------------------------------------------------------------
// plti_ctrl: sequencing controller
// Accepts transactions, walks the table scan, multiply and divide steps,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module plti_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_mode,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  plti_pkg::plti_status_t status,
    output plti_pkg::plti_cmd_t    cmd
);

    plti_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             s_accept;

    assign s_tready = (state_reg == plti_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= plti_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.res_sel   = plti_pkg::RES_CUR_Y;
        cmd.region    = plti_pkg::REGION_BELOW;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            plti_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_mode == plti_pkg::MODE_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = plti_pkg::ST_READ0;
                    end else begin
                        cmd.wr_entry = 1'b1;
                    end
                end
            end
            plti_pkg::ST_READ0: begin
                cmd.idx_inc = 1'b1;
                state_next  = plti_pkg::ST_FIRST;
            end
            plti_pkg::ST_FIRST: begin
                if (status.below) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = plti_pkg::RES_CUR_Y;
                    cmd.region   = plti_pkg::REGION_BELOW;
                    state_next   = plti_pkg::ST_OUT;
                end else if (status.last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = plti_pkg::RES_CUR_Y;
                    cmd.region   = plti_pkg::REGION_BEYOND;
                    state_next   = plti_pkg::ST_OUT;
                end else begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = plti_pkg::ST_SCAN;
                end
            end
            plti_pkg::ST_SCAN: begin
                if (status.hit) begin
                    cmd.seg_load = 1'b1;
                    if (status.span_zero) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = plti_pkg::RES_AVG;
                        cmd.region   = plti_pkg::REGION_INSIDE;
                        state_next   = plti_pkg::ST_OUT;
                    end else begin
                        state_next = plti_pkg::ST_MUL_A;
                    end
                end else if (status.last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = plti_pkg::RES_CUR_Y;
                    cmd.region   = plti_pkg::REGION_BEYOND;
                    state_next   = plti_pkg::ST_OUT;
                end else begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            plti_pkg::ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = plti_pkg::ST_MUL_B;
            end
            plti_pkg::ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = plti_pkg::ST_MUL_C;
            end
            plti_pkg::ST_MUL_C: begin
                cmd.mul_c  = 1'b1;
                state_next = plti_pkg::ST_DIV_PREP;
            end
            plti_pkg::ST_DIV_PREP: begin
                cmd.div_prep = 1'b1;
                state_next   = plti_pkg::ST_DIV;
            end
            plti_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = plti_pkg::ST_DIV_END;
                end
            end
            plti_pkg::ST_DIV_END: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = plti_pkg::RES_QUOT;
                cmd.region   = plti_pkg::REGION_INSIDE;
                state_next   = plti_pkg::ST_OUT;
            end
            plti_pkg::ST_OUT: begin
                // wait for the output register to drain
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = plti_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = plti_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/plti_dp.sv]
// ----------------------------------------------------------------------------
// plti_dp: interpolator datapath
// Breakpoint RAM, scan compare, shared multiplier, restoring divider,
// table length register and output data register.
// ----------------------------------------------------------------------------
module plti_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [plti_pkg::LEN_W-1:0]             cfg_wr_data,
    input  logic [plti_pkg::IDX_W-1:0]             entry_index,
    input  logic signed [plti_pkg::VAL_W-1:0]      entry_x,
    input  logic signed [plti_pkg::VAL_W-1:0]      entry_y,
    input  logic signed [plti_pkg::VAL_W-1:0]      query_value,
    input  plti_pkg::plti_cmd_t                    cmd,
    output plti_pkg::plti_status_t                 status,
    output logic [plti_pkg::VAL_W-1:0]             out_value,
    output plti_pkg::region_t                      out_region
);

    localparam int VW = plti_pkg::VAL_W;
    localparam int PW = plti_pkg::PROD_W;
    localparam int AW = plti_pkg::ADDR_W;
    localparam int CW = plti_pkg::CNT_W;
    localparam int DW = plti_pkg::DIV_CNT_W;

    // Configuration and scan registers
    logic [plti_pkg::LEN_W-1:0] table_length_reg;
    logic [CW-1:0]              n_used;
    logic [CW-1:0]              idx_reg;
    logic signed [VW-1:0]       q_reg;
    logic signed [VW-1:0]       prev_x_reg, prev_y_reg;

    // Segment and arithmetic registers
    logic [VW-1:0]        wl_reg, wr_reg, span_reg;
    logic signed [VW-1:0] yl_reg, yr_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;
    logic [VW-1:0]        rem_reg, quo_reg;
    logic [DW-1:0]        div_cnt_reg;
    logic                 neg_reg;
    logic [VW-1:0]        res_reg;
    plti_pkg::region_t    region_reg;
    logic [VW-1:0]        out_value_reg;
    plti_pkg::region_t    out_region_reg;

    // RAM signals
    logic                 ram_we;
    logic [2*VW-1:0]      ram_rd_data;
    logic signed [VW-1:0] cur_x, cur_y;

    // Combinational helpers
    logic signed [VW:0]   diff_l, diff_r, diff_s;
    logic signed [VW:0]   ysum, ysum_adj;
    logic [VW-1:0]        avg_val;
    logic signed [VW-1:0] mul_op_a;
    logic signed [VW:0]   mul_op_b;
    logic signed [PW:0]   mul_full;
    logic [PW-1:0]        mag;
    logic [VW:0]          div_trial;
    logic [VW:0]          div_diff;
    logic                 div_ge;

    // Breakpoint store: {y, x} per entry
    assign ram_we = cmd.wr_entry && (32'(entry_index) < plti_pkg::TABLE_DEPTH);

    plti_ram #(
        .WIDTH (2 * VW),
        .DEPTH (plti_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(entry_index)),
        .wr_data ({entry_y, entry_x}),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign cur_x = ram_rd_data[VW-1:0];
    assign cur_y = ram_rd_data[2*VW-1:VW];

    // Table length register, clamped to 1..TABLE_DEPTH for use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= plti_pkg::LEN_W'(1);
        end else if (cfg_wr_en) begin
            table_length_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (table_length_reg == '0) begin
            n_used = CW'(1);
        end else if (32'(table_length_reg) > plti_pkg::TABLE_DEPTH) begin
            n_used = CW'(plti_pkg::TABLE_DEPTH);
        end else begin
            n_used = CW'(table_length_reg);
        end
    end

    // Scan compares and segment terms
    assign diff_l   = (VW+1)'(cur_x) - (VW+1)'(q_reg);
    assign diff_r   = (VW+1)'(q_reg) - (VW+1)'(prev_x_reg);
    assign diff_s   = (VW+1)'(cur_x) - (VW+1)'(prev_x_reg);
    assign ysum     = (VW+1)'(prev_y_reg) + (VW+1)'(cur_y);
    assign ysum_adj = ysum + $signed({{VW{1'b0}}, ysum[VW]});
    assign avg_val  = ysum_adj[VW:1];

    assign status.below     = (q_reg < cur_x);
    assign status.hit       = (prev_x_reg <= q_reg) && (cur_x >= q_reg);
    assign status.last      = (idx_reg == n_used);
    assign status.span_zero = (prev_x_reg == cur_x);
    assign status.div_last  = (div_cnt_reg == DW'(plti_pkg::DIV_STEPS - 1));

    // Shared multiplier: signed ordinate by unsigned weight
    assign mul_op_a = cmd.mul_b ? yr_reg : yl_reg;
    assign mul_op_b = $signed({1'b0, (cmd.mul_b ? wr_reg : wl_reg)});
    assign mul_full = mul_op_a * mul_op_b;

    // Divider magnitude and one restoring step
    assign mag       = acc_reg[PW-1] ? PW'(-acc_reg) : acc_reg;
    assign div_trial = {rem_reg, quo_reg[VW-1]};
    assign div_diff  = div_trial - {1'b0, span_reg};
    assign div_ge    = !div_diff[VW];

    // Scan registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_reg   <= query_value;
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.prev_load) begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    // Segment latch, products and divider
    always_ff @(posedge aclk) begin
        if (cmd.seg_load) begin
            wl_reg   <= diff_l[VW-1:0];
            wr_reg   <= diff_r[VW-1:0];
            span_reg <= diff_s[VW-1:0];
            yl_reg   <= prev_y_reg;
            yr_reg   <= cur_y;
        end
        if (cmd.mul_a || cmd.mul_b) begin
            prod_reg <= mul_full[PW-1:0];
        end
        if (cmd.mul_b) begin
            acc_reg <= prod_reg;
        end else if (cmd.mul_c) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.div_prep) begin
            neg_reg     <= acc_reg[PW-1];
            rem_reg     <= mag[PW-1:VW];
            quo_reg     <= mag[VW-1:0];
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= div_ge ? div_diff[VW-1:0] : div_trial[VW-1:0];
            quo_reg     <= {quo_reg[VW-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + DW'(1);
        end
    end

    // Result and output registers
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            region_reg <= cmd.region;
            case (cmd.res_sel)
                plti_pkg::RES_AVG:  res_reg <= avg_val;
                plti_pkg::RES_QUOT: res_reg <= neg_reg ? (VW'(0) - quo_reg) : quo_reg;
                default:            res_reg <= cur_y;
            endcase
        end
        if (cmd.out_load) begin
            out_value_reg  <= res_reg;
            out_region_reg <= region_reg;
        end
    end

    assign out_value  = out_value_reg;
    assign out_region = out_region_reg;

endmodule

[hdl/piecewise_linear_table_interp.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp: breakpoint table interpolator, Q16.16
// Input stream: s_tuser selects a table write (0) or a query (1). A write
// stores one (x, y) breakpoint and gives no result; a query gives one result
// on the output stream, with the ordinate in m_tdata and the region in m_tuser.
// cfg_wr_en/cfg_wr_data set the number of entries in use (reset value 1);
// write it only while no query is in flight.
// Sequence: a write is stored from idle. A query scans the table entries in
// order up to the matched segment through the single read port of the
// breakpoint RAM, then runs the multiply steps ST_MUL_A, ST_MUL_B and
// ST_MUL_C, a setup step and 32 restoring divider steps, one quotient bit per
// cycle, then ST_DIV_END and ST_OUT to output. Results below the table,
// beyond the table or on a zero-width segment skip the multiply and divide.
// One transaction is worked on at a time; s_tready is high only when idle.
// The result sits in an output register: a new transaction is taken while it
// waits, and a finished query holds until m_tready frees that register.
// Reset (aresetn low, synchronous) clears control state and sets the table length to 1;
// table contents are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [plti_pkg::LEN_W-1:0] cfg_wr_data,    // table_length
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [103:0]               s_tdata,        // entry_index[3:0], entry_x[35:4],
                                                       // entry_y[67:36], query_value[99:68]
    input  logic                       s_tuser,        // mode
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,        // result_value[31:0]
    output logic [1:0]                 m_tuser         // region[1:0]
);

    plti_pkg::plti_cmd_t    cmd;
    plti_pkg::plti_status_t status;
    plti_pkg::region_t      out_region;

    plti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plti_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (s_tdata[3:0]),
        .entry_x     (s_tdata[35:4]),
        .entry_y     (s_tdata[67:36]),
        .query_value (s_tdata[99:68]),
        .cmd         (cmd),
        .status      (status),
        .out_value   (m_tdata),
        .out_region  (out_region)
    );

    assign m_tuser = out_region;

endmodule

[bench/tb_piecewise_linear_table_interp.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp: self-checking bench for the interpolator
// Drives table writes and queries on the input stream, predicts each query
// result from a local copy of the breakpoint table and the table length, and
// checks every output transaction field by field. Directed cases cover the
// single-entry table, length zero, zero-width segments and the Q16.16
// extremes; random phases then build sorted and unsorted tables of several
// lengths and query inside segments, on breakpoints, below and above.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interp;

    localparam int IDLE_LIMIT   = 4000;   // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 64;    // longest query plus margin

    typedef struct {
        logic [31:0]       value;
        plti_pkg::region_t region;
    } interp_t;

    // DUT connections
    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [plti_pkg::LEN_W-1:0]     cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [103:0]                   s_tdata;    // entry_index[3:0], entry_x[35:4],
                                                // entry_y[67:36], query_value[99:68]
    logic                           s_tuser;    // mode
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;    // result_value[31:0]
    logic [1:0]                     m_tuser;    // region[1:0]

    // Predictor state: shadow of the table and of the length register
    logic signed [31:0]             bp_x [plti_pkg::TABLE_DEPTH];
    logic signed [31:0]             bp_y [plti_pkg::TABLE_DEPTH];
    logic [plti_pkg::LEN_W-1:0]     table_len;

    interp_t                        pending_interp [$];
    int                             mismatch_count = 0;
    int                             quiet_cycles = 0;
    bit                             steady_source = 1'b0;

    piecewise_linear_table_interp dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Mostly zero, sometimes short, rarely long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int used_entries();
        if (table_len == 0) return 1;
        if (table_len > plti_pkg::TABLE_DEPTH) return plti_pkg::TABLE_DEPTH;
        return int'(table_len);
    endfunction

    // Uniform pick in [lo, hi], span at most 2^32
    function automatic longint rand_between(input longint lo, input longint hi);
        longint u;
        u = $urandom;
        return lo + (u % (hi - lo + 1));
    endfunction

    function automatic logic [31:0] rand_ordinate();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(rand_between(-70000, 70000));
            default: return $urandom;
        endcase
    endfunction

    // Expected output for a query against the shadow table
    function automatic interp_t interpolate_at(input logic signed [31:0] q);
        interp_t r;
        int      n;
        bit      matched;
        longint  xl, xr, yl, yr, qq, span;
        n = used_entries();
        matched = 1'b0;
        qq = q;
        if (q < bp_x[0]) begin
            r.value  = bp_y[0];
            r.region = plti_pkg::REGION_BELOW;
        end else begin
            r.value  = bp_y[n-1];
            r.region = plti_pkg::REGION_BEYOND;
            for (int i = 0; i + 1 < n && !matched; i++) begin
                if (bp_x[i] <= q && bp_x[i+1] >= q) begin
                    matched = 1'b1;
                    xl = bp_x[i];
                    xr = bp_x[i+1];
                    yl = bp_y[i];
                    yr = bp_y[i+1];
                    span = xr - xl;
                    // zero width: midpoint of the ordinates
                    if (span == 0)
                        r.value = 32'((yl + yr) / 2);
                    else
                        r.value = 32'((yl * (xr - qq) + yr * (qq - xl)) / span);
                    r.region = plti_pkg::REGION_INSIDE;
                end
            end
        end
        return r;
    endfunction

    // Query point: inside a segment, on a breakpoint, below, above or anywhere
    function automatic logic [31:0] pick_query(input int n);
        int     i;
        longint xl, xr, lo, hi;
        i  = (n > 1) ? $urandom_range(0, n - 2) : 0;
        xl = bp_x[i];
        xr = (n > 1) ? longint'(bp_x[i+1]) : xl;
        lo = (xl < xr) ? xl : xr;
        hi = (xl < xr) ? xr : xl;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'(rand_between(lo, hi));
            4:          return 32'(xl);
            5:          return 32'(xr);
            6: begin
                if (bp_x[0] != 32'sh8000_0000)
                    return 32'(rand_between(-64'sd2147483648, longint'(bp_x[0]) - 1));
                return 32'(bp_x[0]);
            end
            7: begin
                if (bp_x[n-1] != 32'sh7FFF_FFFF)
                    return 32'(rand_between(longint'(bp_x[n-1]) + 1, 64'sd2147483647));
                return 32'(bp_x[n-1]);
            end
            default:    return $urandom;
        endcase
    endfunction

    // Send one input transaction and update the predictor when it is taken
    task automatic send_item(input logic mode, input logic [3:0] idx,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] qv);
        int gap;
        gap = steady_source ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, qv, ey, ex, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (mode == plti_pkg::MODE_WRITE) begin
            bp_x[idx] = ex;
            bp_y[idx] = ey;
        end else begin
            pending_interp.insert(pending_interp.size(), interpolate_at(qv));
        end
    endtask

    // Length register is written only with nothing in flight
    task automatic set_table_length(input logic [plti_pkg::LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        while (pending_interp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        table_len = len;
    endtask

    task automatic send_query(input logic [31:0] q);
        send_item(plti_pkg::MODE_QUERY, 4'($urandom), $urandom, $urandom, q);
    endtask

    // Length 1 after reset: below, at, and above the only breakpoint
    task automatic test_single_entry();
        send_item(plti_pkg::MODE_WRITE, 4'd0, 32'h0000_0000, 32'h8000_0000, $urandom);
        send_query(32'h8000_0000);
        send_query(32'h0000_0000);
        send_query(32'h7FFF_FFFF);
    endtask

    // Length zero behaves as one entry
    task automatic test_length_zero();
        set_table_length(5'd0);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0007);
    endtask

    // Zero-width segment at the bottom, a full-range segment, zero width on top
    task automatic test_segment_extremes();
        set_table_length(5'd4);
        send_item(plti_pkg::MODE_WRITE, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
        send_item(plti_pkg::MODE_WRITE, 4'd1, 32'h8000_0000, 32'h8000_0000, $urandom);
        send_item(plti_pkg::MODE_WRITE, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom);
        send_item(plti_pkg::MODE_WRITE, 4'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFB, $urandom);
        send_query(32'h8000_0000);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0000);
        send_query(32'h4000_0000);
        send_query(32'h7FFF_FFFF);
    endtask

    // One length setting: fill the used entries, then mostly queries
    task automatic run_table_phase(input logic [plti_pkg::LEN_W-1:0] len_cfg,
                                   input int queries);
        int     n, shape, tmp;
        longint acc;
        int     xs [$];
        set_table_length(len_cfg);
        n = used_entries();
        shape = $urandom_range(0, 4);
        tmp = $urandom;
        acc = tmp / 2;
        for (int i = 0; i < n; i++) begin
            case (shape)
                1:       acc += $urandom_range(0, 3);           // tight, many ties
                2:       acc += $urandom_range(0, 1 << 26);
                default: acc = int'($urandom);                  // full range
            endcase
            xs.insert(xs.size(), int'(acc));
        end
        // shape 3 stays unsorted so some queries miss every segment
        if (shape != 3)
            xs.sort();
        for (int i = 0; i < n; i++)
            send_item(plti_pkg::MODE_WRITE, 4'(i), xs[i], rand_ordinate(), $urandom);
        // queries, with a few stray writes that disturb the table
        for (int k = 0; k < queries; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(plti_pkg::MODE_WRITE, 4'($urandom), $urandom, rand_ordinate(),
                          $urandom);
            else
                send_query(pick_query(n));
        end
    endtask

    task automatic test_random_tables();
        logic [plti_pkg::LEN_W-1:0] lengths [$];
        // first phase uses all sixteen entries so every later read is defined
        lengths = '{5'd31, 5'd16, 5'd2, 5'd1, 5'd9, 5'd17, 5'($urandom_range(3, 15)), 5'd16};
        foreach (lengths[p]) begin
            steady_source = ($urandom_range(0, 3) == 0);
            run_table_phase(lengths[p], 50);
        end
        steady_source = 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = plti_pkg::MODE_WRITE;
        table_len   = 5'd1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_entry();
        test_length_zero();
        test_segment_extremes();
        test_random_tables();

        s_tvalid <= 1'b0;
        while (pending_interp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_piecewise_linear_table_interp OK");
        else
            $display("tb_piecewise_linear_table_interp NOT OK");
        $finish;
    end

    // Result side back-pressure: bursts of ready, random stalls
    initial begin : result_sink
        int run, stall;
        m_tready = 1'b0;
        forever begin
            run   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
            stall = idle_len();
            repeat (run) begin
                @(posedge aclk);
                m_tready <= 1'b1;
            end
            repeat (stall) begin
                @(posedge aclk);
                m_tready <= 1'b0;
            end
        end
    end

    // Compare each output transaction with the oldest expectation
    always @(posedge aclk) begin
        interp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_interp.size() == 0) begin
                $display("%0t: unexpected result, actual value %h region %0d",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_interp.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.region) begin
                    $display("%0t: region expected %0d actual %0d",
                             $time, want.region, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected",
                     $time, pending_interp.size());
            $display("tb_piecewise_linear_table_interp NOT OK");
            $finish;
        end
    end

endmodule
